// ===== rtl/gbs_pkg.sv =====
package gbs_pkg;

    localparam logic [8:0] THRESHOLD_RESET = 9'd115;

    typedef struct packed {
        logic               first_in_set;
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic [14:0]        box_width;
        logic [14:0]        box_height;
    } t_box_in;

    typedef struct packed {
        logic       keep;
        logic [5:0] kept_slot;
        logic       store_full;
    } t_box_result;

    typedef struct packed {
        logic [29:0]        area;
        logic [14:0]        box_height;
        logic [14:0]        box_width;
        logic signed [15:0] box_top;
        logic signed [15:0] box_left;
    } t_kept_entry;

    typedef struct packed {
        logic busy;
        logic hit;
    } t_cmp_status;

endpackage

// ===== rtl/gbs_store.sv =====
module gbs_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  gbs_pkg::t_kept_entry i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output gbs_pkg::t_kept_entry o_rdata
);
    import gbs_pkg::*;

    t_kept_entry r_mem [DEPTH];
    t_kept_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gbs_iou_pipe.sv =====
module gbs_iou_pipe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  gbs_pkg::t_kept_entry i_entry,
    input  gbs_pkg::t_box_in     i_box,
    input  logic [29:0]          i_area,
    input  logic [8:0]           i_thr,
    output gbs_pkg::t_cmp_status o_status
);
    import gbs_pkg::*;

    // Stage A: span ends of the overlap rectangle.
    logic signed [17:0] w_ax0, w_ax1, w_bx0, w_bx1;
    logic signed [17:0] w_ay0, w_ay1, w_by0, w_by1;
    logic signed [17:0] r_lo_x, r_hi_x, r_lo_y, r_hi_y;
    logic [29:0]        r_a_karea;
    logic               r_a_valid;

    // Stage B: overlap lengths.
    logic signed [17:0] w_dx, w_dy;
    logic [14:0]        r_ox, r_oy;
    logic [29:0]        r_b_karea;
    logic               r_b_valid;

    // Stage C: intersection area.
    logic [29:0]        r_c_inter;
    logic [29:0]        r_c_karea;
    logic               r_c_valid;

    // Stage D: union area.
    logic [30:0]        r_d_union;
    logic [29:0]        r_d_inter;
    logic               r_d_valid;

    // Stage E: threshold product.
    logic [39:0]        r_e_prod;
    logic [29:0]        r_e_inter;
    logic               r_e_valid;

    // Stage F: decision.
    logic               r_f_hit;
    logic               r_f_valid;

    assign w_ax0 = {{2{i_box.box_left[15]}}, i_box.box_left};
    assign w_ax1 = w_ax0 + $signed({3'b000, i_box.box_width});
    assign w_bx0 = {{2{i_entry.box_left[15]}}, i_entry.box_left};
    assign w_bx1 = w_bx0 + $signed({3'b000, i_entry.box_width});
    assign w_ay0 = {{2{i_box.box_top[15]}}, i_box.box_top};
    assign w_ay1 = w_ay0 + $signed({3'b000, i_box.box_height});
    assign w_by0 = {{2{i_entry.box_top[15]}}, i_entry.box_top};
    assign w_by1 = w_by0 + $signed({3'b000, i_entry.box_height});

    assign w_dx = r_hi_x - r_lo_x;
    assign w_dy = r_hi_y - r_lo_y;

    always_ff @(posedge i_clk) begin
        r_lo_x    <= (w_ax0 > w_bx0) ? w_ax0 : w_bx0;
        r_hi_x    <= (w_ax1 < w_bx1) ? w_ax1 : w_bx1;
        r_lo_y    <= (w_ay0 > w_by0) ? w_ay0 : w_by0;
        r_hi_y    <= (w_ay1 < w_by1) ? w_ay1 : w_by1;
        r_a_karea <= i_entry.area;

        // A positive difference never exceeds the narrower span, so 15 bits hold it.
        r_ox      <= (w_dx > 18'sd0) ? w_dx[14:0] : 15'd0;
        r_oy      <= (w_dy > 18'sd0) ? w_dy[14:0] : 15'd0;
        r_b_karea <= r_a_karea;

        r_c_inter <= 30'(r_ox) * 30'(r_oy);
        r_c_karea <= r_b_karea;

        r_d_union <= 31'(i_area) + 31'(r_c_karea) - 31'(r_c_inter);
        r_d_inter <= r_c_inter;

        r_e_prod  <= 40'(i_thr) * 40'(r_d_union);
        r_e_inter <= r_d_inter;

        r_f_hit   <= {2'b00, r_e_inter, 8'h00} > r_e_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_e_valid <= r_d_valid;
            r_f_valid <= r_e_valid;
        end
    end

    assign o_status.hit  = r_f_valid & r_f_hit;
    assign o_status.busy = r_a_valid | r_b_valid | r_c_valid | r_d_valid
                         | r_e_valid | r_f_valid;

endmodule

// ===== rtl/greedy_box_suppression_top.sv =====
// Channel   | Ports                              | Transaction
// ----------+------------------------------------+-------------------------------------
// box in    | start, busy, i_box                 | edge with start high and busy low
// result    | o_result_valid, o_result           | one cycle strobe, always taken
// config    | i_cfg_we, i_cfg_data               | edge with i_cfg_we high
//
// With N boxes kept so far in the set, the store is read one entry per cycle through
// its single read port and each entry passes the six stage overlap pipeline; the
// result strobe follows once the pipeline has drained.
// busy falls with the strobe, so the next box can be taken at the edge that ends it.
// Reset is synchronous and active low; it empties the store and loads the
// default threshold. The result receiver cannot stall; busy holds off new boxes.
module greedy_box_suppression_top #(
    parameter int MAX_KEPT = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  gbs_pkg::t_box_in     i_box,
    output logic                 o_result_valid,
    output gbs_pkg::t_box_result o_result,
    input  logic                 i_cfg_we,
    input  logic [8:0]           i_cfg_data
);
    import gbs_pkg::*;

    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW = $clog2(MAX_KEPT + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } t_state;

    t_state      r_state;
    t_box_in     r_box;
    logic [29:0] r_area;
    logic [8:0]  r_thr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic        r_rd_valid;
    logic        r_supp;
    logic        r_out_valid;
    t_box_result r_result;

    logic        w_issue;
    logic        w_done;
    logic        w_keep;
    logic        w_store;
    t_kept_entry w_wentry;
    t_kept_entry w_rentry;
    t_cmp_status w_status;

    assign w_issue = (r_state == S_SCAN) && (r_idx != r_count);
    assign w_done  = (r_state == S_DRAIN) && !r_rd_valid && !w_status.busy;
    assign w_keep  = !(r_supp | w_status.hit);
    assign w_store = w_done && w_keep && (r_count < CW'(MAX_KEPT));

    assign w_wentry.area       = r_area;
    assign w_wentry.box_height = r_box.box_height;
    assign w_wentry.box_width  = r_box.box_width;
    assign w_wentry.box_top    = r_box.box_top;
    assign w_wentry.box_left   = r_box.box_left;

    gbs_store #(
        .DEPTH (MAX_KEPT),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_wentry),
        .i_re    (w_issue),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rentry)
    );

    gbs_iou_pipe u_iou (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_rd_valid),
        .i_entry  (w_rentry),
        .i_box    (r_box),
        .i_area   (r_area),
        .i_thr    (r_thr),
        .o_status (w_status)
    );

    // Payload registers; the box only changes while idle.
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_box <= i_box;
        end
        r_area <= 30'(r_box.box_width) * 30'(r_box.box_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= THRESHOLD_RESET;
            r_count     <= '0;
            r_idx       <= '0;
            r_rd_valid  <= 1'b0;
            r_supp      <= 1'b0;
            r_out_valid <= 1'b0;
            r_result    <= '0;
        end else begin
            r_out_valid <= 1'b0;
            r_rd_valid  <= w_issue;
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_idx   <= '0;
                        r_supp  <= 1'b0;
                        if (i_box.first_in_set) begin
                            r_count <= '0;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_supp <= r_supp | w_status.hit;
                    if (w_issue) begin
                        r_idx <= r_idx + CW'(1);
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_supp <= r_supp | w_status.hit;
                    if (w_done) begin
                        r_out_valid         <= 1'b1;
                        r_result.keep       <= w_keep;
                        r_result.kept_slot  <= w_store ? 6'(r_count) : 6'd0;
                        r_result.store_full <= w_keep && !w_store;
                        if (w_store) begin
                            r_count <= r_count + CW'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_result;

endmodule

// ===== rtl/greedy_box_suppression_chk.sv =====
module greedy_box_suppression_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_result_valid,
    input gbs_pkg::t_box_result o_result
);
    import gbs_pkg::*;

    // An accepted transaction raises busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted box did not raise busy");

    // Each result appears as a single cycle strobe.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    // A result only follows a busy period.
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without a box in progress");

    // A suppressed box reports no slot and no full store.
    a_suppressed_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.keep) |->
            (o_result.kept_slot == 6'd0 && !o_result.store_full))
        else $error("suppressed box carries slot or full flag");

    // A full store is only reported for a kept box with slot zero.
    a_full_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.store_full) |->
            (o_result.keep && o_result.kept_slot == 6'd0))
        else $error("store full flag on a box that was not kept");

endmodule

bind greedy_box_suppression_top greedy_box_suppression_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import gbs_pkg::*;

    typedef longint unsigned u64_t;

    localparam int STORE_DEPTH = 64;
    localparam int PHASE_ITEMS = 120;
    localparam int NUM_PHASES  = 9;
    localparam int TAIL_CYCLES = STORE_DEPTH + 20;

    typedef struct packed {
        t_box_in     box;
        logic        has_want;
        t_box_result want;
    } t_dir_row;

    localparam t_box_result NO_WANT = '0;
    localparam int DIR_ROWS = 16;

    // Rows run at the reset threshold of about 0.45; the expected result is typed in where
    // it is obvious and left to the predictor for the partial overlaps.
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{'{1'b1, 16'sd0, 16'sd0, 15'd160, 15'd160}, 1'b1, '{1'b1, 6'd0, 1'b0}},
        '{'{1'b0, 16'sd0, 16'sd0, 15'd160, 15'd160}, 1'b1, '{1'b0, 6'd0, 1'b0}},
        '{'{1'b0, 16'sd160, 16'sd0, 15'd160, 15'd160}, 1'b1, '{1'b1, 6'd1, 1'b0}},
        '{'{1'b0, 16'sd0, 16'sd0, 15'd0, 15'd0}, 1'b1, '{1'b1, 6'd2, 1'b0}},
        '{'{1'b0, 16'sd0, 16'sd0, 15'd0, 15'd0}, 1'b1, '{1'b1, 6'd3, 1'b0}},
        '{'{1'b0, 16'sh8000, 16'sh8000, 15'h7FFF, 15'h7FFF}, 1'b1, '{1'b1, 6'd4, 1'b0}},
        '{'{1'b0, 16'sh7FFF, 16'sh7FFF, 15'h7FFF, 15'h7FFF}, 1'b1, '{1'b1, 6'd5, 1'b0}},
        '{'{1'b0, 16'sh8000, 16'sh7FFF, 15'd0, 15'h7FFF}, 1'b1, '{1'b1, 6'd6, 1'b0}},
        '{'{1'b0, 16'sd80, 16'sd0, 15'd160, 15'd160}, 1'b0, NO_WANT},
        '{'{1'b0, 16'sd40, 16'sd0, 15'd160, 15'd160}, 1'b0, NO_WANT},
        '{'{1'b0, 16'sd0, 16'sd40, 15'd160, 15'd120}, 1'b0, NO_WANT},
        '{'{1'b0, 16'shFFEC, 16'shFFEC, 15'd200, 15'd200}, 1'b0, NO_WANT},
        '{'{1'b0, 16'sd1000, 16'sd1000, 15'd1, 15'd1}, 1'b0, NO_WANT},
        '{'{1'b1, 16'sd0, 16'sd0, 15'd160, 15'd160}, 1'b1, '{1'b1, 6'd0, 1'b0}},
        '{'{1'b1, 16'shFFFF, 16'shFFFF, 15'h7FFF, 15'd1}, 1'b1, '{1'b1, 6'd0, 1'b0}},
        '{'{1'b0, 16'shFFFF, 16'shFFFF, 15'h7FFF, 15'd1}, 1'b1, '{1'b0, 6'd0, 1'b0}}
    };

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        start      = 1'b0;
    logic        busy;
    t_box_in     i_box      = '0;
    logic        o_result_valid;
    t_box_result o_result;
    logic        i_cfg_we   = 1'b0;
    logic [8:0]  i_cfg_data = '0;

    // Predictor state: the kept boxes of the current set and the active threshold.
    int          kept_left [STORE_DEPTH];
    int          kept_top  [STORE_DEPTH];
    int          kept_w    [STORE_DEPTH];
    int          kept_h    [STORE_DEPTH];
    u64_t        kept_area [STORE_DEPTH];
    int          kept_total = 0;
    logic [8:0]  iou_thresh = THRESHOLD_RESET;

    t_box_result pending_verdicts[$];
    int          fail_count = 0;

    greedy_box_suppression_top #(
        .MAX_KEPT(STORE_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_box         (i_box),
        .o_result_valid(o_result_valid),
        .o_result      (o_result),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic u64_t span_overlap(int a0, int al, int b0, int bl);
        int lo;
        int hi;
        lo = (a0 > b0) ? a0 : b0;
        hi = ((a0 + al) < (b0 + bl)) ? (a0 + al) : (b0 + bl);
        return (hi > lo) ? u64_t'(hi - lo) : u64_t'(0);
    endfunction

    // Runs one box through greedy suppression against the kept set and updates the set.
    function automatic t_box_result judge_box(t_box_in b);
        int          l;
        int          t;
        int          w;
        int          h;
        u64_t        area;
        u64_t        inter;
        u64_t        both;
        bit          keep;
        t_box_result r;
        l    = b.box_left;
        t    = b.box_top;
        w    = int'(b.box_width);
        h    = int'(b.box_height);
        area = u64_t'(w) * u64_t'(h);
        keep = 1'b1;
        if (b.first_in_set) begin
            kept_total = 0;
        end
        for (int j = 0; j < kept_total; j++) begin
            inter = span_overlap(l, w, kept_left[j], kept_w[j])
                  * span_overlap(t, h, kept_top[j], kept_h[j]);
            both  = area + kept_area[j] - inter;
            if (inter * 256 > u64_t'(iou_thresh) * both) begin
                keep = 1'b0;
            end
        end
        r      = '0;
        r.keep = keep;
        if (keep) begin
            if (kept_total < STORE_DEPTH) begin
                kept_left[kept_total] = l;
                kept_top[kept_total]  = t;
                kept_w[kept_total]    = w;
                kept_h[kept_total]    = h;
                kept_area[kept_total] = area;
                r.kept_slot           = 6'(kept_total);
                kept_total++;
            end else begin
                r.store_full = 1'b1;
            end
        end
        return r;
    endfunction

    // Holds the box on the port until it is taken, then records what it should produce.
    task automatic send_box(t_box_in b, bit typed, t_box_result typed_want);
        t_box_result r;
        i_box <= b;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        r = judge_box(b);
        if (typed) begin
            r = typed_want;
        end
        pending_verdicts = {pending_verdicts, r};
    endtask

    task automatic idle_gap(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain_block();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_verdicts.size() != 0 || busy);
    endtask

    task automatic write_threshold(logic [8:0] value);
        drain_block();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        iou_thresh = value;
        i_cfg_we   <= 1'b0;
    endtask

    task automatic pace_and_send(int phase, t_box_in b);
        if (phase != 3) begin
            if ($urandom_range(0, 99) < 30) begin
                idle_gap($urandom_range(1, 100));
            end else if ($urandom_range(0, 63) == 0) begin
                drain_block();
            end
        end
        send_box(b, 1'b0, NO_WANT);
    endtask

    // Non-overlapping grid that overruns the store; the last boxes repeat earlier ones.
    task automatic run_fill_set(int phase, ref int count);
        t_box_in b;
        int      bx;
        int      by;
        int      gw [70];
        int      gh [70];
        bx = int'($urandom_range(0, 40000)) - 20000;
        by = int'($urandom_range(0, 40000)) - 20000;
        for (int k = 0; k < 70; k++) begin
            b              = '0;
            b.first_in_set = (k == 0);
            if (k < 66) begin
                gw[k]        = $urandom_range(1, 63);
                gh[k]        = $urandom_range(1, 63);
                b.box_left   = 16'(bx + (k % 9) * 64);
                b.box_top    = 16'(by + (k / 9) * 64);
                b.box_width  = 15'(gw[k]);
                b.box_height = 15'(gh[k]);
            end else begin
                b.box_left   = 16'(bx + ((k - 60) % 9) * 64);
                b.box_top    = 16'(by + ((k - 60) / 9) * 64);
                b.box_width  = 15'(gw[k - 60]);
                b.box_height = 15'(gh[k - 60]);
            end
            pace_and_send(phase, b);
            count++;
        end
    endtask

    // Boxes scattered around a few centers, so overlaps fall on both sides of the threshold.
    task automatic run_cluster_set(int phase, ref int count);
        t_box_in b;
        int      n;
        int      nc;
        int      sz;
        int      c;
        int      w;
        int      h;
        int      cx [3];
        int      cy [3];
        n  = $urandom_range(1, 24);
        nc = $urandom_range(1, 3);
        sz = $urandom_range(32, 900);
        for (int i = 0; i < 3; i++) begin
            cx[i] = int'($urandom_range(0, 6000)) - 3000;
            cy[i] = int'($urandom_range(0, 6000)) - 3000;
        end
        for (int k = 0; k < n; k++) begin
            c = $urandom_range(0, nc - 1);
            w = sz + int'($urandom_range(0, sz / 2)) - sz / 4;
            h = sz + int'($urandom_range(0, sz / 2)) - sz / 4;
            if ($urandom_range(0, 19) == 0) w = 0;
            if ($urandom_range(0, 19) == 0) h = 0;
            b              = '0;
            b.first_in_set = (k == 0) ? ($urandom_range(0, 7) != 0)
                                      : ($urandom_range(0, 39) == 0);
            b.box_left     = 16'(cx[c] - w / 2 + int'($urandom_range(0, sz / 2)) - sz / 4);
            b.box_top      = 16'(cy[c] - h / 2 + int'($urandom_range(0, sz / 2)) - sz / 4);
            b.box_width    = 15'(w);
            b.box_height   = 15'(h);
            pace_and_send(phase, b);
            count++;
        end
    endtask

    task automatic run_noise_set(int phase, ref int count);
        logic [63:0] raw;
        t_box_in     b;
        int          n;
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
            raw = {$urandom(), $urandom()};
            b   = raw[62:0];
            pace_and_send(phase, b);
            count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_box_result want;
        if (i_rst_n && o_result_valid) begin
            if (pending_verdicts.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result: keep=%0d slot=%0d full=%0d",
                             o_result.keep, o_result.kept_slot, o_result.store_full);
                end
            end else begin
                want = pending_verdicts.pop_front();
                if (o_result.keep !== want.keep || o_result.kept_slot !== want.kept_slot
                        || o_result.store_full !== want.store_full) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display({"result mismatch: expected keep=%0d slot=%0d full=%0d,",
                                  " got keep=%0d slot=%0d full=%0d"},
                                 want.keep, want.kept_slot, want.store_full,
                                 o_result.keep, o_result.kept_slot, o_result.store_full);
                    end
                end
            end
        end
    end

    initial begin
        logic [8:0] phase_thresh [NUM_PHASES];
        int         count;
        int         pick;
        phase_thresh = '{9'd0, 9'd256, 9'd511, 9'd1, 9'd115, 9'd255, 9'd128, 9'd200, 9'd64};
        phase_thresh[NUM_PHASES - 1] = 9'($urandom_range(0, 511));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            send_box(DIR_TABLE[r].box, DIR_TABLE[r].has_want, DIR_TABLE[r].want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_threshold(phase_thresh[p]);
            count = 0;
            while (count < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if ((p == 1 && count == 0) || pick < 8) begin
                    run_fill_set(p, count);
                end else if (pick < 20) begin
                    run_noise_set(p, count);
                end else begin
                    run_cluster_set(p, count);
                end
            end
        end

        drain_block();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        fail_count += pending_verdicts.size();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/gbs_pkg.sv
rtl/gbs_store.sv
rtl/gbs_iou_pipe.sv
rtl/greedy_box_suppression_top.sv
rtl/greedy_box_suppression_chk.sv
tb/tb_top.sv
